/* rtl/mono_page_framebuffer_draw_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the framebuffer draw core
// Each macro expects clk in scope at the point of use; the first also expects rst_n.
// ----------------------------------------------------------------------------
`ifndef MONO_PAGE_FRAMEBUFFER_DRAW_CORE_ASSERT_SVH
`define MONO_PAGE_FRAMEBUFFER_DRAW_CORE_ASSERT_SVH

// Next-cycle implication, switched off while reset is held
`define MPFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also covers the reset itself
`define MPFB_ASSERT_NEXT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mpfb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfb_pkg
// Shared types and constants of the page-organised framebuffer draw core.
// ----------------------------------------------------------------------------
package mpfb_pkg;

  // Field widths fixed by the command format
  localparam int COORD_W = 8;
  localparam int RIDX_W  = 9;
  // Pages never exceed eight, so the user must keep the screen at most 64 rows tall; the core does not enforce it
  localparam int PAGE_W  = 3;
  // Width for byte address arithmetic (largest store is 2048 bytes)
  localparam int CALC_W  = 12;
  // Command queue depth between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_IDX_W   = 3;

  // Command opcodes
  typedef enum logic [2:0] {
    OP_CLEAR        = 3'd0,
    OP_PIXEL        = 3'd1,
    OP_HLINE        = 3'd2,
    OP_VLINE        = 3'd3,
    OP_BLIT_RESTART = 3'd4,
    OP_BLIT_BYTE    = 3'd5,
    OP_READ         = 3'd6
  } opcode_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLIT_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLIT_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLIT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLIT_HEIGHT = 3'd3;

  // Work kinds handed from the front to the back
  typedef enum logic [2:0] {
    JOB_CLEAR,
    JOB_PIXEL,
    JOB_HLINE,
    JOB_VLINE,
    JOB_BLIT_RESTART,
    JOB_BLIT_BYTE,
    JOB_READ
  } job_kind_t;

  // One classified, pre-clipped command
  typedef struct packed {
    job_kind_t           kind;
    logic [COORD_W-1:0]  col_a;   // pixel / hline start / vline column
    logic [COORD_W-1:0]  col_b;   // hline last column
    logic [PAGE_W-1:0]   page_a;  // pixel / hline page, vline first page
    logic [PAGE_W-1:0]   page_b;  // vline last page
    logic [COORD_W-1:0]  y_lo;    // vline first row
    logic [COORD_W-1:0]  y_end;   // vline clipped end row (exclusive)
    logic [7:0]          mask;    // pixel / hline bit within the byte
    logic                val;
    logic [7:0]          src;
    logic [RIDX_W-1:0]   ridx;
    logic                rd_ok;
  } job_t;

  // Blit configuration
  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
  } blit_cfg_t;

endpackage

/* rtl/mpfb_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfb_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mpfb_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 512,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/mpfb_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfb_front
// Command decode: classifies each transfer, clips it against the screen and
// pushes a work descriptor into the queue. Pixels and lines that touch
// nothing, and unused opcodes, are dropped here.
// ----------------------------------------------------------------------------
module mpfb_front
  import mpfb_pkg::*;
#(
  parameter int COLUMNS = 128,
  parameter int ROWS    = 32
) (
  input  logic               accept,
  input  logic [2:0]         opcode,
  input  logic [COORD_W-1:0] x_coord,
  input  logic [COORD_W-1:0] y_coord,
  input  logic [COORD_W-1:0] stop_coord,
  input  logic               pixel_value,
  input  logic [7:0]         source_byte,
  input  logic [RIDX_W-1:0]  read_index,
  output logic               push,
  output job_t               job
);

  localparam int STORE = COLUMNS * ROWS / 8;
  localparam logic [COORD_W:0] COLS_E = (COORD_W+1)'(COLUMNS);
  localparam logic [COORD_W:0] ROWS_E = (COORD_W+1)'(ROWS);

  logic               x_ok, y_ok, keep;
  logic [COORD_W:0]   h_stop, h_last, v_end, v_last;

  // clipping terms
  always_comb begin
    x_ok   = {1'b0, x_coord} < COLS_E;
    y_ok   = {1'b0, y_coord} < ROWS_E;
    h_stop = ({1'b0, stop_coord} > COLS_E) ? COLS_E : {1'b0, stop_coord};
    h_last = h_stop - 1'b1;
    v_end  = ({1'b0, stop_coord} > ROWS_E) ? ROWS_E : {1'b0, stop_coord};
    v_last = v_end - 1'b1;
  end

  // classification
  always_comb begin
    job        = '0;
    job.col_a  = x_coord;
    job.col_b  = h_last[COORD_W-1:0];
    job.page_a = y_coord[PAGE_W+2:3];
    job.page_b = v_last[PAGE_W+2:3];
    job.y_lo   = y_coord;
    job.y_end  = v_end[COORD_W-1:0];
    job.mask   = 8'b1 << y_coord[2:0];
    job.val    = pixel_value;
    job.src    = source_byte;
    job.ridx   = read_index;
    job.rd_ok  = CALC_W'(read_index) < CALC_W'(STORE);
    keep       = 1'b0;
    case (opcode_t'(opcode))
      OP_CLEAR: begin
        job.kind = JOB_CLEAR;
        keep     = 1'b1;
      end
      OP_PIXEL: begin
        job.kind = JOB_PIXEL;
        keep     = x_ok && y_ok;
      end
      OP_HLINE: begin
        job.kind = JOB_HLINE;
        keep     = x_ok && y_ok && (x_coord < stop_coord);
      end
      OP_VLINE: begin
        job.kind = JOB_VLINE;
        keep     = x_ok && y_ok && (y_coord < stop_coord);
      end
      OP_BLIT_RESTART: begin
        job.kind = JOB_BLIT_RESTART;
        keep     = 1'b1;
      end
      OP_BLIT_BYTE: begin
        job.kind = JOB_BLIT_BYTE;
        keep     = 1'b1;
      end
      OP_READ: begin
        job.kind = JOB_READ;
        keep     = 1'b1;
      end
      default: begin
        job.kind = JOB_CLEAR;
        keep     = 1'b0;
      end
    endcase
  end

  assign push = accept && keep;

endmodule

/* rtl/mpfb_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfb_queue
// Short FIFO of work descriptors between the decode front and the draw
// engine, with the head visible before the pop.
// ----------------------------------------------------------------------------
module mpfb_queue
  import mpfb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r;

  assign head  = slot_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == (PTR_W+1)'(QUEUE_DEPTH));

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* rtl/mpfb_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfb_back
// Draw engine: pops work from the queue and carries it out on the frame
// RAM by read-modify-write, one byte at a time. Also owns the clearing
// sweep, the blit cursor and the read result register.
// ----------------------------------------------------------------------------
module mpfb_back
  import mpfb_pkg::*;
#(
  parameter int COLUMNS = 128,
  parameter int ROWS    = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  blit_cfg_t  cfg,
  input  job_t       head,
  input  logic       empty,
  output logic       pop,
  output logic       init_busy,
  output logic       out_valid,
  output logic [7:0] out_read_data
);

  localparam int STORE  = COLUMNS * ROWS / 8;
  localparam int ADDR_W = (STORE > 1) ? $clog2(STORE) : 1;
  localparam logic [COORD_W:0] COLS_E = (COORD_W+1)'(COLUMNS);
  localparam logic [COORD_W:0] ROWS_E = (COORD_W+1)'(ROWS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_BLIT,
    S_MODIFY,
    S_READ
  } state_t;

  state_t             state_r, state_nxt;
  logic               init_r, init_nxt;
  logic [ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [COORD_W-1:0] col_r, col_nxt, col_last_r, col_last_nxt;
  logic [PAGE_W-1:0]  page_r, page_nxt, page_last_r, page_last_nxt;
  logic               vert_r, vert_nxt;
  logic [COORD_W-1:0] y_lo_r, y_lo_nxt, y_end_r, y_end_nxt;
  logic [7:0]         mask_r, mask_nxt;
  logic [ADDR_W-1:0]  tgt_addr_r, tgt_addr_nxt;
  logic               tgt_ok_r, tgt_ok_nxt;
  logic [7:0]         tgt_mask_r, tgt_mask_nxt;
  logic               tgt_val_r, tgt_val_nxt;
  logic               last_r, last_nxt;
  logic               ret_blit_r, ret_blit_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  logic [COORD_W-1:0] blit_row_r, blit_row_nxt;
  logic [4:0]         blit_colb_r, blit_colb_nxt;
  logic [3:0]         bit_r, bit_nxt;
  logic [7:0]         src_r, src_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_data_r, out_data_nxt;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [7:0]         ram_wdata, ram_rdata;

  logic [CALC_W-1:0]  calc;
  logic [COORD_W-1:0] px, bx, by;
  logic [5:0]         per_row;

  // byte address of (page, column)
  function automatic logic [CALC_W-1:0] addr_of(input logic [PAGE_W-1:0] pg,
                                                 input logic [COORD_W-1:0] cl);
    addr_of = CALC_W'(pg) * CALC_W'(COLUMNS) + CALC_W'(cl);
  endfunction

  // bits of a page covered by the row run [lo, hi)
  function automatic logic [7:0] vmask(input logic [PAGE_W-1:0] pg,
                                       input logic [COORD_W-1:0] lo,
                                       input logic [COORD_W-1:0] hi);
    logic [COORD_W-1:0] row;
    logic [7:0]         m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      row  = COORD_W'({pg, 3'(b)});
      m[b] = (row >= lo) && (row < hi);
    end
    vmask = m;
  endfunction

  mpfb_ram #(
    .WIDTH (8),
    .DEPTH (STORE)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // blit cursor terms
  always_comb begin
    px      = {blit_colb_r, bit_r[2:0]};
    bx      = cfg.left + px;
    by      = cfg.top + blit_row_r;
    per_row = 6'(({1'b0, cfg.width} + 9'd7) >> 3);
  end

  // next-state logic and RAM control
  always_comb begin
    state_nxt     = state_r;
    init_nxt      = init_r;
    clr_addr_nxt  = clr_addr_r;
    col_nxt       = col_r;
    col_last_nxt  = col_last_r;
    page_nxt      = page_r;
    page_last_nxt = page_last_r;
    vert_nxt      = vert_r;
    y_lo_nxt      = y_lo_r;
    y_end_nxt     = y_end_r;
    mask_nxt      = mask_r;
    tgt_addr_nxt  = tgt_addr_r;
    tgt_ok_nxt    = tgt_ok_r;
    tgt_mask_nxt  = tgt_mask_r;
    tgt_val_nxt   = tgt_val_r;
    last_nxt      = last_r;
    ret_blit_nxt  = ret_blit_r;
    rd_ok_nxt     = rd_ok_r;
    blit_row_nxt  = blit_row_r;
    blit_colb_nxt = blit_colb_r;
    bit_nxt       = bit_r;
    src_nxt       = src_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = tgt_addr_r;
    ram_wdata     = tgt_val_r ? (ram_rdata | tgt_mask_r) : (ram_rdata & ~tgt_mask_r);
    ram_raddr     = '0;
    calc          = '0;

    case (state_r)
      // one byte zeroed per cycle
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
        if (clr_addr_r == ADDR_W'(STORE - 1)) begin
          state_nxt = S_IDLE;
          init_nxt  = 1'b0;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end

      // take the next job; single-byte jobs issue their read at once
      S_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          case (head.kind)
            JOB_CLEAR: begin
              clr_addr_nxt = '0;
              state_nxt    = S_CLEAR;
            end
            JOB_PIXEL: begin
              calc         = addr_of(head.page_a, head.col_a);
              ram_raddr    = calc[ADDR_W-1:0];
              tgt_addr_nxt = calc[ADDR_W-1:0];
              tgt_ok_nxt   = calc < CALC_W'(STORE);
              tgt_mask_nxt = head.mask;
              tgt_val_nxt  = head.val;
              last_nxt     = 1'b1;
              state_nxt    = S_MODIFY;
            end
            JOB_HLINE: begin
              col_nxt      = head.col_a;
              col_last_nxt = head.col_b;
              page_nxt     = head.page_a;
              mask_nxt     = head.mask;
              vert_nxt     = 1'b0;
              state_nxt    = S_WALK;
            end
            JOB_VLINE: begin
              col_nxt       = head.col_a;
              page_nxt      = head.page_a;
              page_last_nxt = head.page_b;
              y_lo_nxt      = head.y_lo;
              y_end_nxt     = head.y_end;
              vert_nxt      = 1'b1;
              state_nxt     = S_WALK;
            end
            JOB_BLIT_RESTART: begin
              blit_row_nxt  = '0;
              blit_colb_nxt = '0;
            end
            JOB_BLIT_BYTE: begin
              if ((cfg.width != '0) && (cfg.height != '0) && (blit_row_r < cfg.height)) begin
                bit_nxt   = '0;
                src_nxt   = head.src;
                state_nxt = S_BLIT;
              end
            end
            JOB_READ: begin
              calc      = CALC_W'(head.ridx);
              ram_raddr = calc[ADDR_W-1:0];
              rd_ok_nxt = head.rd_ok;
              state_nxt = S_READ;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // line walk: columns for hline, pages for vline
      S_WALK: begin
        calc         = addr_of(page_r, col_r);
        ram_raddr    = calc[ADDR_W-1:0];
        tgt_addr_nxt = calc[ADDR_W-1:0];
        tgt_ok_nxt   = calc < CALC_W'(STORE);
        tgt_mask_nxt = vert_r ? vmask(page_r, y_lo_r, y_end_r) : mask_r;
        tgt_val_nxt  = 1'b1;
        ret_blit_nxt = 1'b0;
        if (vert_r) begin
          last_nxt = (page_r == page_last_r);
          page_nxt = page_r + 1'b1;
        end else begin
          last_nxt = (col_r == col_last_r);
          col_nxt  = col_r + 1'b1;
        end
        state_nxt = S_MODIFY;
      end

      // one source bit per visit; off-screen bits are skipped
      S_BLIT: begin
        if (bit_r[3] || (px >= cfg.width)) begin
          if ((6'(blit_colb_r) + 6'd1) >= per_row) begin
            blit_colb_nxt = '0;
            blit_row_nxt  = blit_row_r + 1'b1;
          end else begin
            blit_colb_nxt = blit_colb_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end else begin
          bit_nxt = bit_r + 1'b1;
          if (({1'b0, bx} < COLS_E) && ({1'b0, by} < ROWS_E)) begin
            calc         = addr_of(by[PAGE_W+2:3], bx);
            ram_raddr    = calc[ADDR_W-1:0];
            tgt_addr_nxt = calc[ADDR_W-1:0];
            tgt_ok_nxt   = calc < CALC_W'(STORE);
            tgt_mask_nxt = 8'b1 << by[2:0];
            tgt_val_nxt  = src_r[bit_r[2:0]];
            last_nxt     = 1'b0;
            ret_blit_nxt = 1'b1;
            state_nxt    = S_MODIFY;
          end
        end
      end

      // write back the modified byte
      S_MODIFY: begin
        ram_we = tgt_ok_r;
        if (last_r) begin
          state_nxt = S_IDLE;
        end else if (ret_blit_r) begin
          state_nxt = S_BLIT;
        end else begin
          state_nxt = S_WALK;
        end
      end

      // read data arrives from the RAM register
      S_READ: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = rd_ok_r ? ram_rdata : 8'h00;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      init_r      <= 1'b1;
      clr_addr_r  <= '0;
      blit_row_r  <= '0;
      blit_colb_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      clr_addr_r  <= clr_addr_nxt;
      blit_row_r  <= blit_row_nxt;
      blit_colb_r <= blit_colb_nxt;
      out_valid_r <= out_valid_nxt;
    end
    col_r       <= col_nxt;
    col_last_r  <= col_last_nxt;
    page_r      <= page_nxt;
    page_last_r <= page_last_nxt;
    vert_r      <= vert_nxt;
    y_lo_r      <= y_lo_nxt;
    y_end_r     <= y_end_nxt;
    mask_r      <= mask_nxt;
    tgt_addr_r  <= tgt_addr_nxt;
    tgt_ok_r    <= tgt_ok_nxt;
    tgt_mask_r  <= tgt_mask_nxt;
    tgt_val_r   <= tgt_val_nxt;
    last_r      <= last_nxt;
    ret_blit_r  <= ret_blit_nxt;
    rd_ok_r     <= rd_ok_nxt;
    bit_r       <= bit_nxt;
    src_r       <= src_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign init_busy     = init_r;
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

endmodule

/* rtl/mono_page_framebuffer_draw_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_page_framebuffer_draw_core
// 1 bit per pixel framebuffer, COLUMNS x ROWS, page organised (eight
// vertical pixels per byte, top pixel in bit 0), with draw and read commands.
// ----------------------------------------------------------------------------
// A command transfers when start is high and busy is low. Decoded commands
// wait in a four-entry queue ahead of the draw engine, so busy only rises
// when that queue is full or during the clearing sweep that follows reset
// (which zeroes all COLUMNS*ROWS/8 bytes, 512 at the default size). All
// drawing is a read-modify-write of the frame RAM through its single write
// port. The engine takes each job from its idle state, and for a pixel that
// step also issues the RAM read, so a pixel then only writes its byte back.
// An hline reads and writes each column drawn, a vline each page spanned, a
// blit byte each visible pixel, with one visit per skipped bit and one more
// to advance the cursor. A clear zeroes every byte in turn; a blit restart
// or an ignored blit byte needs nothing past being taken. A read returns its
// byte on out_read_data with out_valid high for a single cycle, through the
// RAM read register and then the result register; there is no way to hold a
// result off, so it must be captured when it appears.
// Configuration writes take effect at once and are meant for an idle core.
// ----------------------------------------------------------------------------
module mono_page_framebuffer_draw_core
  import mpfb_pkg::*;
#(
  parameter int COLUMNS = 128,
  parameter int ROWS    = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           in_opcode,
  input  logic [COORD_W-1:0]   in_x_coord,
  input  logic [COORD_W-1:0]   in_y_coord,
  input  logic [COORD_W-1:0]   in_stop_coord,
  input  logic                 in_pixel_value,
  input  logic [7:0]           in_source_byte,
  input  logic [RIDX_W-1:0]    in_read_index,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  output logic                 out_valid,
  output logic [7:0]           out_read_data
);

  blit_cfg_t cfg_r;
  logic      accept, push, pop, q_empty, q_full, init_busy;
  job_t      push_job, head;

  assign busy   = q_full || init_busy;
  assign accept = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_BLIT_LEFT:   cfg_r.left   <= cfg_data;
        CFG_BLIT_TOP:    cfg_r.top    <= cfg_data;
        CFG_BLIT_WIDTH:  cfg_r.width  <= cfg_data;
        CFG_BLIT_HEIGHT: cfg_r.height <= cfg_data;
        default:         cfg_r        <= cfg_r;
      endcase
    end
  end

  mpfb_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .accept      (accept),
    .opcode      (in_opcode),
    .x_coord     (in_x_coord),
    .y_coord     (in_y_coord),
    .stop_coord  (in_stop_coord),
    .pixel_value (in_pixel_value),
    .source_byte (in_source_byte),
    .read_index  (in_read_index),
    .push        (push),
    .job         (push_job)
  );

  mpfb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  mpfb_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .head          (head),
    .empty         (q_empty),
    .pop           (pop),
    .init_busy     (init_busy),
    .out_valid     (out_valid),
    .out_read_data (out_read_data)
  );

endmodule

/* rtl/mpfb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfb_checker
// Port-level assertions for the framebuffer draw core, bound to the top.
// ----------------------------------------------------------------------------
`include "mono_page_framebuffer_draw_core_assert.svh"

module mpfb_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid
);

  // a read result is a single-cycle strobe
  `MPFB_ASSERT_NEXT(a_result_single, out_valid, !out_valid, "result strobe held twice")

  // reset starts the clearing sweep, so commands are refused
  `MPFB_ASSERT_NEXT_RST(a_reset_busy, !rst_n, busy, "busy low right after reset")

  // no result survives a reset
  `MPFB_ASSERT_NEXT_RST(a_reset_quiet, !rst_n, !out_valid, "result strobe after reset")

endmodule

bind mono_page_framebuffer_draw_core mpfb_checker u_mpfb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid)
);

/* tb/mono_page_framebuffer_draw_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_page_framebuffer_draw_core_tb
// Self-checking bench for the page-organised framebuffer draw core. A shadow
// frame store, blit cursor and register set follow every accepted command;
// each read result is compared with the byte the shadow held at that point.
// Directed tests hit the clipping, empty-run, wrap and ignored-byte cases,
// then random phases stream blits, draws and reads under bursty pacing.
// ----------------------------------------------------------------------------
module mono_page_framebuffer_draw_core_tb;
  import mpfb_pkg::*;

  localparam int COLUMNS        = 128;
  localparam int ROWS           = 32;
  localparam int STORE_BYTES    = COLUMNS * ROWS / 8;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 145;
  localparam int SETTLE_CYCLES  = 16;
  localparam int DRAIN_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 10;

  localparam logic [2:0]           OP_SPARE        = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd4;

  // One command as it crosses the input channel
  typedef struct packed {
    logic [2:0]         opcode;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] stop;
    logic               val;
    logic [7:0]         src;
    logic [RIDX_W-1:0]  ridx;
  } draw_cmd_t;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 start          = 1'b0;
  logic                 busy;
  logic [2:0]           in_opcode      = '0;
  logic [COORD_W-1:0]   in_x_coord     = '0;
  logic [COORD_W-1:0]   in_y_coord     = '0;
  logic [COORD_W-1:0]   in_stop_coord  = '0;
  logic                 in_pixel_value = 1'b0;
  logic [7:0]           in_source_byte = '0;
  logic [RIDX_W-1:0]    in_read_index  = '0;
  logic                 cfg_write_en   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [COORD_W-1:0]   cfg_data       = '0;
  logic                 out_valid;
  logic [7:0]           out_read_data;

  // Shadow of the core's state
  logic [7:0]         frame_shadow [STORE_BYTES];
  logic [7:0]         shadow_row;
  logic [4:0]         shadow_col_byte;
  logic [COORD_W-1:0] shadow_left, shadow_top, shadow_width, shadow_height;

  logic [7:0] expected_reads [$];
  logic [7:0] wanted_byte;

  int fail_count   = 0;
  int reads_seen   = 0;
  int stall_cycles = 0;
  int burst_left   = 0;
  int settings     = 0;
  int op_count [8];

  always #1 clk = ~clk;

  mono_page_framebuffer_draw_core #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_x_coord    (in_x_coord),
    .in_y_coord    (in_y_coord),
    .in_stop_coord (in_stop_coord),
    .in_pixel_value(in_pixel_value),
    .in_source_byte(in_source_byte),
    .in_read_index (in_read_index),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_read_data (out_read_data)
  );

  // ---------------------------------------------------------------- shadow --

  function automatic void shadow_put(int px, int py, logic on);
    int         idx;
    logic [7:0] bitmask;
    if (px >= COLUMNS || py >= ROWS) return;
    idx     = (py >> 3) * COLUMNS + px;
    bitmask = 8'h01 << (py & 7);
    if (on) frame_shadow[idx] = frame_shadow[idx] | bitmask;
    else    frame_shadow[idx] = frame_shadow[idx] & ~bitmask;
  endfunction

  function automatic void shadow_blit(logic [7:0] src);
    int per_row, pos;
    per_row = (int'(shadow_width) + 7) >> 3;
    if (shadow_width == 0 || shadow_height == 0 || shadow_row >= shadow_height) return;
    for (int i = 0; i < 8; i++) begin
      pos = int'(shadow_col_byte) * 8 + i;
      if (pos < int'(shadow_width))
        shadow_put((int'(shadow_left) + pos) & 255,
                   (int'(shadow_top) + int'(shadow_row)) & 255, src[i]);
    end
    if (int'(shadow_col_byte) + 1 >= per_row) begin
      shadow_col_byte = '0;
      shadow_row      = shadow_row + 8'd1;
    end else begin
      shadow_col_byte = shadow_col_byte + 5'd1;
    end
  endfunction

  // Follow one transferred command; a read queues the byte it must return
  function automatic void shadow_apply(draw_cmd_t c);
    case (c.opcode)
      OP_CLEAR: begin
        for (int i = 0; i < STORE_BYTES; i++) frame_shadow[i] = '0;
      end
      OP_PIXEL: shadow_put(int'(c.x), int'(c.y), c.val);
      OP_HLINE: begin
        for (int k = int'(c.x); k < int'(c.stop); k++) shadow_put(k, int'(c.y), 1'b1);
      end
      OP_VLINE: begin
        for (int k = int'(c.y); k < int'(c.stop); k++) shadow_put(int'(c.x), k, 1'b1);
      end
      OP_BLIT_RESTART: begin
        shadow_row      = '0;
        shadow_col_byte = '0;
      end
      OP_BLIT_BYTE: shadow_blit(c.src);
      OP_READ: begin
        if (int'(c.ridx) < STORE_BYTES) expected_reads.push_back(frame_shadow[c.ridx]);
        else                            expected_reads.push_back(8'h00);
      end
      default: ;
    endcase
  endfunction

  // ------------------------------------------------------------- stimulus --

  function automatic draw_cmd_t make_cmd(logic [2:0] op, int x, int y, int stop,
                                         int val, int src, int ridx);
    draw_cmd_t c;
    c.opcode = op;
    c.x      = COORD_W'(x);
    c.y      = COORD_W'(y);
    c.stop   = COORD_W'(stop);
    c.val    = val[0];
    c.src    = 8'(src);
    c.ridx   = RIDX_W'(ridx);
    return c;
  endfunction

  // Random content in every field; callers override what matters
  function automatic draw_cmd_t random_cmd(logic [2:0] op);
    return make_cmd(op, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 1),
                    $urandom_range(0, 255), $urandom_range(0, 511));
  endfunction

  // Mostly on or just past the screen edge, now and then anywhere
  function automatic int near_x();
    return ($urandom_range(0, 4) != 0) ? $urandom_range(0, COLUMNS + 8) : $urandom_range(0, 255);
  endfunction

  function automatic int near_y();
    return ($urandom_range(0, 4) != 0) ? $urandom_range(0, ROWS + 8) : $urandom_range(0, 255);
  endfunction

  function automatic int byte_index(int px, int py);
    if (px >= COLUMNS || py >= ROWS) return $urandom_range(0, STORE_BYTES - 1);
    return (py >> 3) * COLUMNS + px;
  endfunction

  // Drive one command and hold it until it transfers
  task automatic send_cmd(draw_cmd_t c);
    start          <= 1'b1;
    in_opcode      <= c.opcode;
    in_x_coord     <= c.x;
    in_y_coord     <= c.y;
    in_stop_coord  <= c.stop;
    in_pixel_value <= c.val;
    in_source_byte <= c.src;
    in_read_index  <= c.ridx;
    @(posedge clk);
    while (busy) @(posedge clk);
    shadow_apply(c);
    op_count[c.opcode]++;
  endtask

  // Read one byte, with noise in the fields a read ignores
  task automatic read_byte(int idx);
    draw_cmd_t c;
    c      = random_cmd(OP_READ);
    c.ridx = RIDX_W'(idx);
    send_cmd(c);
  endtask

  // Bursts of random length separated by random gaps
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      gap = $urandom_range(0, 10);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Fence with a read, then let the engine go quiet before touching registers
  task automatic settle();
    send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, $urandom_range(0, STORE_BYTES - 1)));
    start <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= COORD_W'(value);
    @(posedge clk);
    case (idx)
      CFG_BLIT_LEFT:   shadow_left   = COORD_W'(value);
      CFG_BLIT_TOP:    shadow_top    = COORD_W'(value);
      CFG_BLIT_WIDTH:  shadow_width  = COORD_W'(value);
      CFG_BLIT_HEIGHT: shadow_height = COORD_W'(value);
      default: ;
    endcase
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_blit(int left, int top, int width, int height);
    cfg_write(CFG_BLIT_LEFT, left);
    cfg_write(CFG_BLIT_TOP, top);
    cfg_write(CFG_BLIT_WIDTH, width);
    cfg_write(CFG_BLIT_HEIGHT, height);
    settings++;
  endtask

  // --------------------------------------------------------------- tests --

  task automatic test_after_reset();
    @(posedge clk);
    while (busy) @(posedge clk);
    cfg_blit(0, 0, 0, 0);
    read_byte(0);
    read_byte(STORE_BYTES - 1);
  endtask

  task automatic test_pixels();
    send_cmd(make_cmd(OP_PIXEL, 0, 0, 0, 1, 0, 0));
    send_cmd(make_cmd(OP_PIXEL, COLUMNS - 1, ROWS - 1, 0, 1, 0, 0));
    // Off-screen pixels must not alias into a neighbouring byte
    send_cmd(make_cmd(OP_PIXEL, COLUMNS, 0, 0, 1, 0, 0));
    send_cmd(make_cmd(OP_PIXEL, 0, ROWS, 0, 1, 0, 0));
    send_cmd(make_cmd(OP_PIXEL, 255, 255, 0, 1, 0, 0));
    read_byte(STORE_BYTES - 1);
    read_byte(COLUMNS);
    send_cmd(make_cmd(OP_PIXEL, 0, 0, 0, 0, 0, 0));
    read_byte(0);
    settle();
  endtask

  task automatic test_lines();
    // hline running off the right edge, then an empty one
    send_cmd(make_cmd(OP_HLINE, 120, 9, 255, 0, 0, 0));
    send_cmd(make_cmd(OP_HLINE, 50, 9, 50, 0, 0, 0));
    send_cmd(make_cmd(OP_HLINE, 0, 40, 255, 0, 0, 0));
    read_byte(COLUMNS + COLUMNS - 1);
    read_byte(COLUMNS + 50);
    // vline past the bottom, then one with stop below start
    send_cmd(make_cmd(OP_VLINE, 5, 3, 255, 0, 0, 0));
    send_cmd(make_cmd(OP_VLINE, 6, 20, 10, 0, 0, 0));
    read_byte(5);
    read_byte(3 * COLUMNS + 5);
    read_byte(2 * COLUMNS + 6);
    settle();
  endtask

  task automatic test_blit();
    // Bitmap straddling the bottom right corner, one spare byte past the end
    cfg_blit(124, 30, 12, 3);
    send_cmd(make_cmd(OP_BLIT_RESTART, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 7; i++) send_cmd(make_cmd(OP_BLIT_BYTE, 0, 0, 0, 0, 8'hA5 ^ i, 0));
    read_byte(3 * COLUMNS + 124);
    read_byte(3 * COLUMNS + 127);
    settle();
    // Empty bitmap: bytes are dropped
    cfg_blit(0, 0, 0, 4);
    send_cmd(make_cmd(OP_BLIT_RESTART, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_BLIT_BYTE, 0, 0, 0, 0, 8'hFF, 0));
    read_byte(0);
    settle();
  endtask

  task automatic test_misc();
    send_cmd(make_cmd(OP_SPARE, 3, 3, 9, 1, 8'hFF, 0));
    settle();
    // Indexes past the last register write nothing
    for (int i = 0; i < 4; i++) cfg_write(CFG_IDX_W'(CFG_SPARE_FIRST + i), 8'hFF);
    send_cmd(make_cmd(OP_BLIT_RESTART, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_BLIT_BYTE, 0, 0, 0, 0, 8'hFF, 0));
    send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    read_byte(3 * COLUMNS + 127);
    settle();
  endtask

  // One well-formed (sometimes cut short or overrun) bitmap transfer
  task automatic random_blit(ref int done);
    int n, rows_done;
    int per_row;
    per_row = (int'(shadow_width) + 7) >> 3;
    n = per_row * int'(shadow_height);
    if (n > 260 || n == 0) n = $urandom_range(1, 40);
    if ($urandom_range(0, 5) == 0) n = $urandom_range(0, n);
    else if ($urandom_range(0, 5) == 0) n = n + $urandom_range(1, 2);
    pace();
    send_cmd(random_cmd(OP_BLIT_RESTART));
    for (int i = 0; i < n; i++) begin
      pace();
      send_cmd(random_cmd(OP_BLIT_BYTE));
    end
    done += n + 1;
    rows_done = $urandom_range(0, (shadow_height > 8) ? 7 : int'(shadow_height));
    for (int i = 0; i < 2; i++) begin
      pace();
      read_byte(byte_index((int'(shadow_left) + $urandom_range(0, 15)) & 255,
                           (int'(shadow_top) + rows_done + 8 * i) & 255));
    end
    done += 2;
  endtask

  task automatic random_phase(int kind);
    int done;
    int pick;
    int x0;
    draw_cmd_t c;
    case (kind)
      0: cfg_blit($urandom_range(0, 140), $urandom_range(0, 40),
                  $urandom_range(1, 24), $urandom_range(1, 10));
      1: cfg_blit($urandom_range(230, 255), $urandom_range(240, 255),
                  $urandom_range(1, 40), $urandom_range(1, 24));
      2: cfg_blit(0, 0, $urandom_range(0, 1) ? 0 : 9, 0);
      3: cfg_blit($urandom_range(0, 255), $urandom_range(0, 31), 255, $urandom_range(1, 2));
      4: cfg_blit($urandom_range(0, 127), $urandom_range(0, 255), $urandom_range(1, 8), 255);
      default: cfg_blit(255, 255, 255, 255);
    endcase
    done = 0;
    while (done < PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        random_blit(done);
      end else begin
        c = random_cmd(OP_READ);
        if (pick < 55) begin
          c.opcode = OP_PIXEL;
          c.x = COORD_W'(near_x());
          c.y = COORD_W'(near_y());
        end else if (pick < 65) begin
          x0 = near_x();
          c.opcode = OP_HLINE;
          c.x = COORD_W'(x0);
          c.y = COORD_W'(near_y());
          if ($urandom_range(0, 3) != 0) c.stop = COORD_W'((x0 + $urandom_range(0, 40) > 255)
                                                  ? 255 : x0 + $urandom_range(0, 40));
        end else if (pick < 75) begin
          x0 = near_y();
          c.opcode = OP_VLINE;
          c.x = COORD_W'(near_x());
          c.y = COORD_W'(x0);
          if ($urandom_range(0, 3) != 0) c.stop = COORD_W'(x0 + $urandom_range(0, 30));
        end else if (pick < 95) begin
          c.opcode = OP_READ;
        end else if (pick == 95) begin
          c.opcode = OP_CLEAR;
        end else if (pick < 98) begin
          c.opcode = OP_BLIT_BYTE;
        end else begin
          c.opcode = 3'($urandom_range(0, 7));
          if (c.opcode == OP_CLEAR) c.opcode = OP_SPARE;
        end
        pace();
        send_cmd(c);
        done++;
      end
    end
    settle();
  endtask

  // ------------------------------------------------------------- checking --

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      reads_seen++;
      if (expected_reads.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("read result 0x%02h with no read outstanding", out_read_data);
      end else begin
        wanted_byte = expected_reads.pop_front();
        if (out_read_data !== wanted_byte) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("read_data mismatch: expected 0x%02h, got 0x%02h",
                     wanted_byte, out_read_data);
        end
      end
    end
  end

  // Watchdog on cycles with no transfer of any kind
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_write_en) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("no transfer for %0d cycles, %0d reads outstanding",
               stall_cycles, expected_reads.size());
      $display("tb: failure");
      $finish;
    end
  end

  // ------------------------------------------------------------- sequence --

  initial begin
    for (int i = 0; i < STORE_BYTES; i++) frame_shadow[i] = '0;
    for (int i = 0; i < 8; i++) op_count[i] = 0;
    shadow_row      = '0;
    shadow_col_byte = '0;
    shadow_left     = '0;
    shadow_top      = '0;
    shadow_width    = '0;
    shadow_height   = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_pixels();
    test_lines();
    test_blit();
    test_misc();
    for (int p = 0; p < RANDOM_PHASES; p++)
      random_phase((p < 6) ? p : $urandom_range(0, 5));

    start <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_reads.size() != 0) fail_count++;

    $display("covered %0d clears, %0d pixels, %0d hlines, %0d vlines, %0d spare opcodes",
             op_count[OP_CLEAR], op_count[OP_PIXEL], op_count[OP_HLINE],
             op_count[OP_VLINE], op_count[OP_SPARE]);
    $display("%0d blit restarts, %0d blit bytes, %0d reads checked over %0d register settings",
             op_count[OP_BLIT_RESTART], op_count[OP_BLIT_BYTE], reads_seen, settings);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d failures", fail_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
